/* sv/alht_pkg.sv */
// Package for the alarm hold-time tracker.
// Holds request codes, the hh:mm:ss time format and its one-second increment.
// No dependencies.
package alht_pkg;

    localparam int TICK_ALARMS    = 28;
    localparam int PRODUCER_FIRST = 16;
    localparam int SIXTY          = 60;
    localparam int HMS_W          = 28;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_SET     = 2'd1,
        REQ_READ    = 2'd2,
        REQ_CLR_ALL = 2'd3
    } t_req;

    typedef struct packed {
        logic [15:0] hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_hms;

    typedef struct packed {
        logic tick;
        logic prod;
        logic stack;
    } t_tmr_ctl;

    function automatic t_hms hms_inc(input t_hms t);
        t_hms r;
        r = t;
        if (t.seconds == 6'(SIXTY - 1)) begin
            r.seconds = '0;
            if (t.minutes == 6'(SIXTY - 1)) begin
                r.minutes = '0;
                r.hours   = t.hours + 16'd1;
            end else begin
                r.minutes = t.minutes + 6'd1;
            end
        end else begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

endpackage

/* sv/alht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module alht_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/alht_timers.sv */
// Run, producer-total and stack-total time counters of the alarm hold-time tracker.
// Depends on alht_pkg.
module alht_timers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  alht_pkg::t_tmr_ctl i_ctl,
    output logic [15:0]        o_run_hours,
    output logic [15:0]        o_producer_total_hours,
    output logic [15:0]        o_stack_total_hours
);

    alht_pkg::t_hms r_run, r_prod, r_stack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_prod  <= '0;
            r_stack <= '0;
        end else if (i_ctl.tick) begin
            r_run <= alht_pkg::hms_inc(r_run);
            if (i_ctl.prod) begin
                r_prod <= alht_pkg::hms_inc(r_prod);
            end
            if (i_ctl.stack) begin
                r_stack <= alht_pkg::hms_inc(r_stack);
            end
        end
    end

    assign o_run_hours            = r_run.hours;
    assign o_producer_total_hours = r_prod.hours;
    assign o_stack_total_hours    = r_stack.hours;

endmodule

/* sv/alarm_hold_time_tracker_unit.sv */
// Alarm hold-time tracker: 32 alarm flags with per-alarm hold-time counters in RAM.
// A new request is accepted only while idle (busy low); a tick walks the RAM over 28
// hold counters, one read and one write per cycle. Results cannot be stalled.
// Synchronous active-low reset clears flags, all hold times (valid bits) and timers.
// Depends on alht_pkg, alht_ram, alht_timers.
module alarm_hold_time_tracker_unit #(
    parameter int NUM_ALARMS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_alarm_index,
    input  logic        i_alarm_on,
    input  logic        i_producer_running,
    input  logic        i_stack_working,
    output logic        o_strobe,
    output logic [31:0] o_alarm_word,
    output logic        o_alarm_active,
    output logic [15:0] o_hold_hours,
    output logic [5:0]  o_hold_minutes,
    output logic [5:0]  o_hold_seconds,
    output logic [15:0] o_run_hours,
    output logic [15:0] o_producer_total_hours,
    output logic [15:0] o_stack_total_hours
);

    localparam int AW = $clog2(NUM_ALARMS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMD   = 6'b000010,
        S_WALK  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_RD    = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    alht_pkg::t_req      r_req;
    logic [4:0]          r_idx;
    logic                r_on, r_prod, r_stack;
    logic [NUM_ALARMS-1:0] r_flags;
    logic [NUM_ALARMS-1:0] r_hvalid;
    logic [AW-1:0]       r_k;
    logic                r_wr_act;
    logic [AW-1:0]       r_wk;
    logic                r_strobe;
    logic                r_active;
    alht_pkg::t_hms      r_hold;

    logic                idx_ok;
    logic [AW-1:0]       idx_a;
    logic [AW-1:0]       raddr;
    logic                we;
    alht_pkg::t_hms      rd_hms, cur_hms, inc_hms;
    logic [alht_pkg::HMS_W-1:0] rdata;
    logic                sel;
    alht_pkg::t_tmr_ctl  tmr_ctl;

    assign idx_ok = {1'b0, r_idx} < 6'(NUM_ALARMS);
    assign idx_a  = r_idx[AW-1:0];
    assign raddr  = (r_state == S_WALK) ? r_k : idx_a;
    assign rd_hms = alht_pkg::t_hms'(rdata);

    // walk stage two: data of entry r_wk is back from RAM
    assign cur_hms = r_hvalid[r_wk] ? rd_hms : '0;
    assign inc_hms = alht_pkg::hms_inc(cur_hms);
    assign sel     = r_flags[r_wk] &&
                     ((r_wk >= AW'(alht_pkg::PRODUCER_FIRST)) ? r_prod : r_stack);
    assign we      = r_wr_act && sel;

    assign tmr_ctl.tick  = (r_state == S_CMD) && (r_req == alht_pkg::REQ_TICK);
    assign tmr_ctl.prod  = r_prod;
    assign tmr_ctl.stack = r_stack;

    alht_ram #(
        .WIDTH (alht_pkg::HMS_W),
        .DEPTH (NUM_ALARMS)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wk),
        .i_wdata (inc_hms),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    alht_timers u_timers (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_ctl                  (tmr_ctl),
        .o_run_hours            (o_run_hours),
        .o_producer_total_hours (o_producer_total_hours),
        .o_stack_total_hours    (o_stack_total_hours)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CMD;
            end
            S_CMD: begin
                n_state = (r_req == alht_pkg::REQ_TICK) ? S_WALK : S_RD;
            end
            S_WALK: begin
                if (r_k == AW'(alht_pkg::TICK_ALARMS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_RD;
            S_RD:    n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flags  <= '0;
            r_hvalid <= '0;
            r_k      <= '0;
            r_wr_act <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            r_wr_act <= (r_state == S_WALK);
            r_wk     <= r_k;
            if (r_state == S_WALK) begin
                r_k <= r_k + AW'(1);
            end else begin
                r_k <= '0;
            end
            if (we) begin
                r_hvalid[r_wk] <= 1'b1;
            end
            if (r_state == S_CMD) begin
                if (r_req == alht_pkg::REQ_SET) begin
                    if (idx_ok && (r_flags[idx_a] != r_on)) begin
                        r_flags[idx_a]  <= r_on;
                        r_hvalid[idx_a] <= 1'b0;
                    end
                end else if (r_req == alht_pkg::REQ_CLR_ALL) begin
                    r_flags  <= '0;
                    r_hvalid <= '0;
                end
            end
            if (r_state == S_RESP) begin
                r_strobe <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req   <= alht_pkg::t_req'(i_req_type);
            r_idx   <= i_alarm_index;
            r_on    <= i_alarm_on;
            r_prod  <= i_producer_running;
            r_stack <= i_stack_working;
        end
        if (r_state == S_RESP) begin
            r_active <= idx_ok && r_flags[idx_a];
            r_hold   <= (idx_ok && r_hvalid[idx_a]) ? rd_hms : '0;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_alarm_word   = 32'(r_flags);
    assign o_alarm_active = r_active;
    assign o_hold_hours   = r_hold.hours;
    assign o_hold_minutes = r_hold.minutes;
    assign o_hold_seconds = r_hold.seconds;

endmodule

/* tb/sv/alarm_hold_time_tracker_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for alarm_hold_time_tracker_unit: directed and random requests,
// predicted by a scoreboard class that mirrors the alarm flags, hold times and timers.
// Depends on alht_pkg and the alarm_hold_time_tracker_unit RTL.
module alarm_hold_time_tracker_unit_tb;
    import alht_pkg::*;

    localparam int NUM_ALARMS  = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQS = 1900;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [31:0] alarm_word;
        logic        alarm_active;
        t_hms        hold;
        logic [15:0] run_hours;
        logic [15:0] producer_hours;
        logic [15:0] stack_hours;
    } t_report;

    class hold_time_book;
        logic [31:0] flags;
        t_hms        hold_time [32];
        t_hms        run_time;
        t_hms        producer_run;
        t_hms        producer_total;
        t_hms        stack_run;
        t_hms        stack_total;
        t_report     expected_reports [$];
        int          errors;

        function new();
            flags = '0;
            foreach (hold_time[k]) hold_time[k] = '0;
            run_time       = '0;
            producer_run   = '0;
            producer_total = '0;
            stack_run      = '0;
            stack_total    = '0;
            errors         = 0;
        endfunction

        function t_hms one_second(t_hms t);
            t_hms r;
            r = t;
            if (t.seconds != 6'd59) begin
                r.seconds = t.seconds + 6'd1;
            end else begin
                r.seconds = '0;
                if (t.minutes != 6'd59) begin
                    r.minutes = t.minutes + 6'd1;
                end else begin
                    r.minutes = '0;
                    r.hours   = t.hours + 16'd1;
                end
            end
            return r;
        endfunction

        function void advance_alarms(int first, int last);
            for (int k = first; k <= last; k++) begin
                if (k < NUM_ALARMS && flags[k]) hold_time[k] = one_second(hold_time[k]);
            end
        endfunction

        function void note_request(t_req req, logic [4:0] idx, logic on,
                                   logic prod, logic stack);
            t_report r;
            logic    idx_ok;
            idx_ok = (int'(idx) < NUM_ALARMS);
            case (req)
                REQ_TICK: begin
                    run_time = one_second(run_time);
                    if (prod) begin
                        producer_run   = one_second(producer_run);
                        producer_total = one_second(producer_total);
                        advance_alarms(PRODUCER_FIRST, TICK_ALARMS - 1);
                    end
                    if (stack) begin
                        stack_run   = one_second(stack_run);
                        stack_total = one_second(stack_total);
                        advance_alarms(0, PRODUCER_FIRST - 1);
                    end
                end
                REQ_SET: begin
                    if (idx_ok && flags[idx] != on) begin
                        hold_time[idx] = '0;
                        flags[idx]     = on;
                    end
                end
                REQ_CLR_ALL: begin
                    flags = '0;
                    foreach (hold_time[k]) hold_time[k] = '0;
                end
                default: ;
            endcase
            r.alarm_word     = flags;
            r.alarm_active   = idx_ok ? flags[idx] : 1'b0;
            r.hold           = idx_ok ? hold_time[idx] : '0;
            r.run_hours      = run_time.hours;
            r.producer_hours = producer_total.hours;
            r.stack_hours    = stack_total.hours;
            expected_reports.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
        endtask

        task check_report(t_report got);
            t_report want;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected strobe, alarm_word", got.alarm_word, '0);
            end else begin
                want = expected_reports.pop_front();
                if (got.alarm_word !== want.alarm_word)
                    report_mismatch("alarm_word", got.alarm_word, want.alarm_word);
                if (got.alarm_active !== want.alarm_active)
                    report_mismatch("alarm_active", 32'(got.alarm_active),
                                    32'(want.alarm_active));
                if (got.hold.hours !== want.hold.hours)
                    report_mismatch("hold_hours", 32'(got.hold.hours), 32'(want.hold.hours));
                if (got.hold.minutes !== want.hold.minutes)
                    report_mismatch("hold_minutes", 32'(got.hold.minutes),
                                    32'(want.hold.minutes));
                if (got.hold.seconds !== want.hold.seconds)
                    report_mismatch("hold_seconds", 32'(got.hold.seconds),
                                    32'(want.hold.seconds));
                if (got.run_hours !== want.run_hours)
                    report_mismatch("run_hours", 32'(got.run_hours), 32'(want.run_hours));
                if (got.producer_hours !== want.producer_hours)
                    report_mismatch("producer_total_hours", 32'(got.producer_hours),
                                    32'(want.producer_hours));
                if (got.stack_hours !== want.stack_hours)
                    report_mismatch("stack_total_hours", 32'(got.stack_hours),
                                    32'(want.stack_hours));
            end
        endtask

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [4:0]  i_alarm_index;
    logic        i_alarm_on;
    logic        i_producer_running;
    logic        i_stack_working;
    logic        o_strobe;
    logic [31:0] o_alarm_word;
    logic        o_alarm_active;
    logic [15:0] o_hold_hours;
    logic [5:0]  o_hold_minutes;
    logic [5:0]  o_hold_seconds;
    logic [15:0] o_run_hours;
    logic [15:0] o_producer_total_hours;
    logic [15:0] o_stack_total_hours;

    hold_time_book book;
    bit            idle_enabled;
    int unsigned   cycles;

    alarm_hold_time_tracker_unit #(.NUM_ALARMS(NUM_ALARMS)) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_req_type             (i_req_type),
        .i_alarm_index          (i_alarm_index),
        .i_alarm_on             (i_alarm_on),
        .i_producer_running     (i_producer_running),
        .i_stack_working        (i_stack_working),
        .o_strobe               (o_strobe),
        .o_alarm_word           (o_alarm_word),
        .o_alarm_active         (o_alarm_active),
        .o_hold_hours           (o_hold_hours),
        .o_hold_minutes         (o_hold_minutes),
        .o_hold_seconds         (o_hold_seconds),
        .o_run_hours            (o_run_hours),
        .o_producer_total_hours (o_producer_total_hours),
        .o_stack_total_hours    (o_stack_total_hours)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            book.check_report({o_alarm_word, o_alarm_active,
                               o_hold_hours, o_hold_minutes, o_hold_seconds,
                               o_run_hours, o_producer_total_hours, o_stack_total_hours});
        end
    end

    task send_request(t_req req, logic [4:0] idx, logic on, logic prod, logic stack);
        @(negedge i_clk);
        while (idle_enabled && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start              <= 1'b1;
        i_req_type         <= req;
        i_alarm_index      <= idx;
        i_alarm_on         <= on;
        i_producer_running <= prod;
        i_stack_working    <= stack;
        do @(posedge i_clk); while (busy);
        book.note_request(req, idx, on, prod, stack);
    endtask

    task send_random_request();
        int   pick;
        t_req req;
        pick = $urandom_range(0, 99);
        if (pick < 62)      req = REQ_TICK;
        else if (pick < 82) req = REQ_SET;
        else if (pick < 99) req = REQ_READ;
        else                req = REQ_CLR_ALL;
        // alarms mostly raised, timers mostly running, so hold times build up
        send_request(req, 5'($urandom_range(0, 31)), $urandom_range(0, 99) < 65,
                     $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 80);
    endtask

    initial begin
        book               = new();
        cycles             = 0;
        idle_enabled       = 1'b1;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_req_type         = REQ_READ;
        i_alarm_index      = '0;
        i_alarm_on         = 1'b0;
        i_producer_running = 1'b0;
        i_stack_working    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(REQ_READ, 5'd0, 1'b1, 1'b1, 1'b1);
        send_request(REQ_SET, 5'd0, 1'b1, 1'b0, 1'b0);
        send_request(REQ_SET, 5'd15, 1'b1, 1'b1, 1'b0);
        send_request(REQ_SET, 5'd16, 1'b1, 1'b0, 1'b1);
        send_request(REQ_SET, 5'd27, 1'b1, 1'b0, 1'b0);
        send_request(REQ_SET, 5'd28, 1'b1, 1'b1, 1'b1);
        send_request(REQ_SET, 5'd31, 1'b1, 1'b0, 1'b0);
        send_request(REQ_SET, 5'd0, 1'b1, 1'b0, 1'b0);
        send_request(REQ_TICK, 5'd0, 1'b1, 1'b1, 1'b1);
        send_request(REQ_TICK, 5'd16, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 5'd15, 1'b1, 1'b0, 1'b1);
        send_request(REQ_TICK, 5'd28, 1'b0, 1'b0, 1'b0);
        send_request(REQ_READ, 5'd31, 1'b0, 1'b1, 1'b1);
        send_request(REQ_READ, 5'd27, 1'b1, 1'b0, 1'b0);
        send_request(REQ_SET, 5'd0, 1'b0, 1'b1, 1'b1);
        send_request(REQ_READ, 5'd0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_SET, 5'd5, 1'b0, 1'b0, 1'b0);
        send_request(REQ_TICK, 5'd27, 1'b1, 1'b1, 1'b1);
        send_request(REQ_CLR_ALL, 5'd16, 1'b1, 1'b1, 1'b1);
        send_request(REQ_READ, 5'd16, 1'b1, 1'b1, 1'b1);
        send_request(REQ_SET, 5'd31, 1'b1, 1'b1, 1'b1);
        send_request(REQ_TICK, 5'd31, 1'b0, 1'b1, 1'b1);
        send_request(REQ_READ, 5'd31, 1'b0, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            idle_enabled = !(n >= 800 && n < 1100);
            send_random_request();
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (book.pending() != 0)
            book.report_mismatch("results never seen", book.pending(), '0);

        if (book.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/alht_pkg.sv
sv/alht_ram.sv
sv/alht_timers.sv
sv/alarm_hold_time_tracker_unit.sv
tb/sv/alarm_hold_time_tracker_unit_tb.sv
